// ----- design/line_continuation_filter_macros.svh -----
// Assertion macros shared by the line continuation filter.
`ifndef LINE_CONTINUATION_FILTER_MACROS_SVH
`define LINE_CONTINUATION_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line continuation filter check failed");

// Next-cycle implication, checked outside reset.
`define LCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line continuation filter check failed");

`endif

// ----- design/lcf_pkg.sv -----
// Shared types, constants and control interfaces of the line continuation filter.
package lcf_pkg;

  localparam int STARTER_MAX_DEF  = 8;
  localparam int COUNT_DIGITS_DEF = 10;
  localparam int CFG_IDX_W        = 2;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INFO_ENABLE    = 2'd0,
    CFG_STARTER_CHARS  = 2'd1,
    CFG_STARTER_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_STARTER,
    ST_SPACE,
    ST_DIGIT,
    ST_EOL
  } state_t;

  typedef enum logic [2:0] {
    SRC_IN,
    SRC_BACKSLASH,
    SRC_NEWLINE,
    SRC_STARTER,
    SRC_SPACE,
    SRC_DIGIT
  } out_src_t;

  typedef struct packed {
    logic     process;
    logic     consume;
    logic     out_load;
    out_src_t out_sel;
    logic     out_last;
    logic     starter_step;
    logic     digit_load;
    logic     digit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_full;
    logic is_newline;
    logic is_backslash;
    logic escape_pending;
    logic joined_run;
    logic out_free;
    logic starter_empty;
    logic starter_last;
    logic digit_last;
  } dp_status_t;

endpackage

// ----- design/lcf_ctrl.sv -----
// Sequencer that steps one request through its output bytes.
module lcf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  lcf_pkg::dp_status_t status,
  output lcf_pkg::ctrl_cmd_t  cmd
);

  lcf_pkg::state_t state;
  lcf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.out_sel = lcf_pkg::SRC_IN;
    state_next = state;
    unique case (state)
      lcf_pkg::ST_IDLE: begin
        if (status.in_full && status.out_free) begin
          cmd.process = 1'b1;
          priority if (status.escape_pending) begin
            if (status.is_newline) begin
              // joined newline: drop both bytes
              cmd.consume = 1'b1;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = lcf_pkg::SRC_BACKSLASH;
              state_next   = lcf_pkg::ST_ESC;
            end
          end else if (status.is_backslash) begin
            cmd.consume = 1'b1;
          end else if (status.is_newline) begin
            cmd.consume  = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_sel  = lcf_pkg::SRC_IN;
            cmd.out_last = !status.joined_run;
            if (status.joined_run) begin
              state_next = status.starter_empty ? lcf_pkg::ST_SPACE : lcf_pkg::ST_STARTER;
            end
          end else begin
            cmd.consume  = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_sel  = lcf_pkg::SRC_IN;
            cmd.out_last = 1'b1;
          end
        end
      end
      lcf_pkg::ST_ESC: begin
        if (status.out_free) begin
          cmd.consume  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_sel  = lcf_pkg::SRC_IN;
          cmd.out_last = 1'b1;
          state_next   = lcf_pkg::ST_IDLE;
        end
      end
      lcf_pkg::ST_STARTER: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel      = lcf_pkg::SRC_STARTER;
          cmd.starter_step = 1'b1;
          if (status.starter_last) begin
            state_next = lcf_pkg::ST_SPACE;
          end
        end
      end
      lcf_pkg::ST_SPACE: begin
        if (status.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = lcf_pkg::SRC_SPACE;
          cmd.digit_load = 1'b1;
          state_next     = lcf_pkg::ST_DIGIT;
        end
      end
      lcf_pkg::ST_DIGIT: begin
        if (status.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = lcf_pkg::SRC_DIGIT;
          cmd.digit_step = 1'b1;
          if (status.digit_last) begin
            state_next = lcf_pkg::ST_EOL;
          end
        end
      end
      lcf_pkg::ST_EOL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lcf_pkg::SRC_NEWLINE;
          cmd.out_last = 1'b1;
          state_next   = lcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lcf_dp.sv -----
// Datapath: input and output registers, settings, line counters and byte select.
module lcf_dp #(
  parameter int STARTER_MAX  = lcf_pkg::STARTER_MAX_DEF,
  parameter int COUNT_DIGITS = lcf_pkg::COUNT_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                 cfg_data,
  input  lcf_pkg::ctrl_cmd_t          cmd,
  output lcf_pkg::dp_status_t         status
);

  localparam int SIDX_W = (STARTER_MAX > 1) ? $clog2(STARTER_MAX) : 1;
  localparam int DIDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
  localparam int BCD_W  = 4 * COUNT_DIGITS;

  logic                     in_full;
  logic [7:0]               held_byte;
  logic                     info_enable;
  logic [8*STARTER_MAX-1:0] starter_chars;
  logic [3:0]               starter_length;
  logic                     escape_pending;
  logic                     joined_run;
  logic [31:0]              line_count;
  logic [BCD_W-1:0]         line_count_bcd;
  logic [SIDX_W-1:0]        starter_idx;
  logic [DIDX_W-1:0]        digit_idx;

  logic [31:0]              line_count_next;
  logic [BCD_W-1:0]         bcd_next;
  logic [3:0]               len_eff;
  logic [DIDX_W-1:0]        top_digit;
  logic [7:0]               sel_byte;
  logic                     out_free;
  logic                     is_newline;
  logic                     is_backslash;

  assign out_free     = !out_valid || !out_stall;
  assign in_stall     = in_full && !cmd.consume;
  assign is_newline   = (held_byte == lcf_pkg::CH_NEWLINE);
  assign is_backslash = (held_byte == lcf_pkg::CH_BACKSLASH);

  assign len_eff = (starter_length > 4'(STARTER_MAX)) ? 4'(STARTER_MAX) : starter_length;

  assign status.in_full        = in_full;
  assign status.is_newline     = is_newline;
  assign status.is_backslash   = is_backslash;
  assign status.escape_pending = escape_pending;
  assign status.joined_run     = joined_run;
  assign status.out_free       = out_free;
  assign status.starter_empty  = (len_eff == 4'd0);
  assign status.starter_last   = ((4'(starter_idx) + 4'd1) == len_eff);
  assign status.digit_last     = (digit_idx == '0);

  // Decimal increment: a digit steps up when all lower digits are nine, and a nine rolls over to zero.
  assign line_count_next = line_count + 32'd1;
  always_comb begin
    logic       carry;
    logic [3:0] d;
    carry    = 1'b1;
    bcd_next = line_count_bcd;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      d = line_count_bcd[4*i +: 4];
      if (carry) begin
        if (d >= 4'd9) begin
          bcd_next[4*i +: 4] = 4'd0;
        end else begin
          bcd_next[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (line_count_next == 32'd0) begin
      bcd_next = '0;
    end
  end

  // Highest nonzero digit; a zero value prints one digit.
  always_comb begin
    top_digit = '0;
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (line_count_bcd[4*i +: 4] != 4'd0) begin
        top_digit = DIDX_W'(i);
      end
    end
  end

  always_comb begin
    unique case (cmd.out_sel)
      lcf_pkg::SRC_IN:        sel_byte = held_byte;
      lcf_pkg::SRC_BACKSLASH: sel_byte = lcf_pkg::CH_BACKSLASH;
      lcf_pkg::SRC_NEWLINE:   sel_byte = lcf_pkg::CH_NEWLINE;
      lcf_pkg::SRC_STARTER:   sel_byte = starter_chars[8*starter_idx +: 8];
      lcf_pkg::SRC_SPACE:     sel_byte = lcf_pkg::CH_SPACE;
      lcf_pkg::SRC_DIGIT:     sel_byte = lcf_pkg::CH_ZERO + {4'd0, line_count_bcd[4*digit_idx +: 4]};
      default:                sel_byte = held_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_valid      <= 1'b0;
      info_enable    <= 1'b0;
      starter_chars  <= '0;
      starter_length <= 4'd0;
      escape_pending <= 1'b0;
      joined_run     <= 1'b0;
      line_count     <= 32'd1;
      line_count_bcd <= BCD_W'(1);
      starter_idx    <= '0;
      digit_idx      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (cmd.consume) begin
        in_full <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lcf_pkg::CFG_INFO_ENABLE:    info_enable    <= cfg_data[0];
          lcf_pkg::CFG_STARTER_CHARS:  starter_chars  <= cfg_data[8*STARTER_MAX-1:0];
          lcf_pkg::CFG_STARTER_LENGTH: starter_length <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (cmd.process) begin
        starter_idx <= '0;
        priority if (escape_pending) begin
          escape_pending <= 1'b0;
          if (is_newline) begin
            line_count     <= line_count_next;
            line_count_bcd <= bcd_next;
            if (info_enable) begin
              joined_run <= 1'b1;
            end
          end
        end else if (is_backslash) begin
          escape_pending <= 1'b1;
        end else if (is_newline) begin
          line_count     <= line_count_next;
          line_count_bcd <= bcd_next;
          joined_run     <= 1'b0;
        end else begin
          escape_pending <= 1'b0;
        end
      end

      if (cmd.starter_step) begin
        starter_idx <= starter_idx + SIDX_W'(1);
      end

      if (cmd.digit_load) begin
        digit_idx <= top_digit;
      end else if (cmd.digit_step) begin
        digit_idx <= digit_idx - DIDX_W'(1);
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
    end
    if (cmd.out_load) begin
      out_byte <= sel_byte;
      last     <= cmd.out_last;
    end
  end

endmodule

// ----- design/line_continuation_filter.sv -----
// Top level of the line continuation filter: sequencer, datapath and checks.
// Path: a byte taken into the input register is processed into the output register.
// Throughput: one byte per cycle for plain bytes while out_stall is low. A backslash emits
// nothing, a byte other than newline after it emits a backslash and itself, an info line
// emits starter, space, digits, newline; the single output register that every byte passes paces them.
// Reset: line counter to 1, flags and settings to 0, both channels empty.
`include "line_continuation_filter_macros.svh"

module line_continuation_filter #(
  parameter int STARTER_MAX  = lcf_pkg::STARTER_MAX_DEF,
  parameter int COUNT_DIGITS = lcf_pkg::COUNT_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  lcf_pkg::ctrl_cmd_t  cmd;
  lcf_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  lcf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lcf_dp #(
    .STARTER_MAX  (STARTER_MAX),
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  `LCF_ASSERT_NOW(a_load_needs_room, cmd.out_load, status.out_free)
  `LCF_ASSERT_NOW(a_consume_needs_byte, cmd.consume, status.in_full)
  `LCF_ASSERT_NEXT(a_escape_cleared, cmd.process && status.escape_pending, !status.escape_pending)

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the line continuation filter: byte stream stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_top;
  import lcf_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  // Predicts the filtered text and holds the characters still owed by the block.
  class joined_line_scoreboard;
    out_char_t   owed_q[$];
    bit          info_on;
    logic [63:0] starter;
    logic [3:0]  starter_len;
    bit          esc_held;
    bit          run_joined;
    logic [31:0] lines;
    logic [39:0] lines_bcd;
    int          errors;
    int          results;
    int          joins;
    int          info_lines;

    function new();
      info_on     = 1'b0;
      starter     = '0;
      starter_len = '0;
      esc_held    = 1'b0;
      run_joined  = 1'b0;
      lines       = 32'd1;
      lines_bcd   = 40'd1;
      errors      = 0;
      results     = 0;
      joins       = 0;
      info_lines  = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        CFG_INFO_ENABLE:    info_on = v[0];
        CFG_STARTER_CHARS:  starter = v;
        CFG_STARTER_LENGTH: starter_len = v[3:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [7:0] ch);
      out_char_t c;
      c.ch   = ch;
      c.last = 1'b0;
      owed_q.push_back(c);
    endfunction

    function void bump_line();
      int i;
      lines = lines + 32'd1;
      if (lines == 32'd0) begin
        lines_bcd = '0;
      end else begin
        for (i = 0; i < COUNT_DIGITS_DEF; i++) begin
          if (lines_bcd[4*i +: 4] >= 4'd9) begin
            lines_bcd[4*i +: 4] = 4'd0;
          end else begin
            lines_bcd[4*i +: 4] = lines_bcd[4*i +: 4] + 4'd1;
            break;
          end
        end
      end
    endfunction

    function void owe_info_line();
      int i;
      int n;
      int top;
      n = (starter_len > STARTER_MAX_DEF) ? STARTER_MAX_DEF : int'(starter_len);
      for (i = 0; i < n; i++) owe(starter[8*i +: 8]);
      owe(CH_SPACE);
      // drop leading zero digits, keep at least one
      top = 0;
      for (i = COUNT_DIGITS_DEF - 1; i > 0; i--) begin
        if (lines_bcd[4*i +: 4] != 4'd0) begin
          top = i;
          break;
        end
      end
      for (i = top; i >= 0; i--) owe(CH_ZERO + {4'd0, lines_bcd[4*i +: 4]});
      owe(CH_NEWLINE);
      info_lines++;
    endfunction

    function void note_byte(logic [7:0] b);
      out_char_t tail;
      if (esc_held) begin
        esc_held = 1'b0;
        if (b == CH_NEWLINE) begin
          bump_line();
          if (info_on) run_joined = 1'b1;
          joins++;
          return;
        end
        owe(CH_BACKSLASH);
        owe(b);
      end else if (b == CH_BACKSLASH) begin
        esc_held = 1'b1;
        return;
      end else if (b == CH_NEWLINE) begin
        bump_line();
        owe(b);
        if (run_joined) begin
          run_joined = 1'b0;
          owe_info_line();
        end
      end else begin
        owe(b);
      end
      tail = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    endfunction

    function void check_result(logic [7:0] ch, logic is_last);
      out_char_t w;
      results++;
      if (owed_q.size() == 0) begin
        $error("unexpected output: out_byte %02h last %0b", ch, is_last);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (ch !== w.ch) begin
        $error("out_byte mismatch: expected %02h, actual %02h", w.ch, ch);
        errors++;
      end
      if (is_last !== w.last) begin
        $error("last mismatch: expected %0b, actual %0b", w.last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_byte;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  joined_line_scoreboard sb;
  int bytes_sent;
  bit quiet;
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_req;
  int stall_left;

  line_continuation_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** line_continuation_filter: FAILED **");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (long_hold_req) begin
          stall_left    = LONG_HOLD;
          long_hold_req = 1'b0;
        end else if (!quiet && rx_idle_on && $urandom_range(0, 6) == 0) begin
          stall_left = $urandom_range(1, 14);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_byte, last);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every owed character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Drain, then let requests that produce no output clear the pipeline.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input bit info, input logic [63:0] chars, input logic [3:0] len);
    settle();
    write_reg(CFG_INFO_ENABLE, {63'd0, info});
    write_reg(CFG_STARTER_CHARS, chars);
    write_reg(CFG_STARTER_LENGTH, {60'd0, len});
  endtask

  // Mostly well-formed text: lines, joined lines and escapes, with some raw noise.
  task automatic random_text(input int count);
    int stop_at;
    int r;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_byte(CH_BACKSLASH);
        send_byte(CH_NEWLINE);
      end else if (r < 30) begin
        send_byte(CH_NEWLINE);
      end else if (r < 37) begin
        send_byte(CH_BACKSLASH);
        send_byte(8'($urandom));
      end else if (r < 40) begin
        send_byte(CH_BACKSLASH);
      end else if (r < 75) begin
        send_byte(8'($urandom_range(32, 126)));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    sb            = new();
    bytes_sent    = 0;
    quiet         = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    long_hold_req = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = 8'd0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_INFO_ENABLE;
    cfg_data      = 64'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: byte extremes, escapes, joins with info mode off.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte("a");
    send_byte(CH_BACKSLASH);
    send_byte(CH_NEWLINE);
    send_byte(CH_NEWLINE);
    send_byte(CH_BACKSLASH);
    send_byte("x");
    // second backslash is passed on, not a new escape
    send_byte(CH_BACKSLASH);
    send_byte(CH_BACKSLASH);
    send_byte(CH_BACKSLASH);
    send_byte(CH_NEWLINE);

    // Over-long starter with zero bytes inside it.
    configure(1'b1, 64'h2A002F2F00003E23, 4'd15);
    send_byte(CH_BACKSLASH);
    send_byte(CH_NEWLINE);
    send_byte("b");
    send_byte(CH_NEWLINE);

    // Arm an info line, then turn info mode off before the plain newline.
    settle();
    send_byte(CH_BACKSLASH);
    send_byte(CH_NEWLINE);
    settle();
    write_reg(CFG_INFO_ENABLE, 64'd0);
    send_byte(CH_NEWLINE);

    configure(1'b1, {$urandom, $urandom}, 4'($urandom_range(1, 8)));
    // Long receiver hold while the sender keeps pushing.
    tx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    random_text(35);
    tx_idle_on = 1'b1;
    random_text(25);
    wait_drained();
    random_text(25);

    configure(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    tx_idle_on = 1'b0;
    random_text(50);

    configure(1'b0, 64'd0, 4'd0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    random_text(40);

    configure(1'b1, {$urandom, $urandom}, 4'd8);
    rx_idle_on = 1'b1;
    random_text(40);

    configure(1'b1, {$urandom, $urandom}, 4'd0);
    quiet = 1'b1;
    random_text(50);
    // a lone trailing backslash stays held
    send_byte(CH_BACKSLASH);

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d bytes over several starter settings; %0d output chars checked.",
             bytes_sent, sb.results);
    $display("Saw %0d joined newlines and %0d info lines; last line number %0d.",
             sb.joins, sb.info_lines, sb.lines);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** line_continuation_filter: PASSED **");
    end else begin
      $display("** line_continuation_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/lcf_pkg.sv
design/lcf_ctrl.sv
design/lcf_dp.sv
design/line_continuation_filter.sv
bench/tb_top.sv
